// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files of the convolution unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define RGBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define RGBC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/rgbc_pkg.sv =====
`default_nettype none

package rgbc_pkg;

  localparam int unsigned COEFF_BITS_DEF = 8;
  localparam int unsigned PIX_W          = 24;
  localparam int unsigned CH_W           = 8;
  localparam int unsigned NUM_CH         = 3;
  localparam int unsigned NUM_TAPS       = 9;
  localparam int unsigned DIV_W          = 16;
  // Quotient bits per channel: eight result bits plus one saturation bit.
  localparam int unsigned Q_BITS         = CH_W + 1;
  // Pipeline depth of the multiply-accumulate lane.
  localparam int unsigned MAC_STAGES     = 3;
  // Reset value of the middle kernel row before masking to the row width.
  localparam logic [63:0] KMID_RST       = 64'h0000_0000_0001_0000;

  typedef enum logic [1:0] {
    REG_KTOP = 2'd0,
    REG_KMID = 2'd1,
    REG_KBOT = 2'd2,
    REG_NDIV = 2'd3
  } cfg_reg_e;

  // One channel of a 3x3 window, tap 0 is the top-left pixel.
  typedef logic [NUM_TAPS-1:0][CH_W-1:0] chan_win_t;

  // Width of a signed channel sum for a given coefficient width.
  function automatic int unsigned sum_width(input int unsigned coeff_bits);
    return coeff_bits + CH_W + 1 + 4;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgbc_mac_lane.sv =====
`default_nettype none

// Nine signed products and their sum for one color channel.
module rgbc_mac_lane import rgbc_pkg::*; #(
  parameter int unsigned COEFF_BITS = COEFF_BITS_DEF,
  localparam int unsigned PROD_W = COEFF_BITS + CH_W + 1,
  localparam int unsigned PART_W = PROD_W + 2,
  localparam int unsigned SUM_W  = sum_width(COEFF_BITS)
) (
  input  logic                             clk_i,
  input  chan_win_t                        win_i,
  input  logic [NUM_TAPS*COEFF_BITS-1:0]   coeff_i,
  output logic signed [SUM_W-1:0]          sum_o
);

  logic signed [PROD_W-1:0] prod_d [NUM_TAPS];
  logic signed [PROD_W-1:0] prod_q [NUM_TAPS];
  logic signed [PART_W-1:0] part_d [3];
  logic signed [PART_W-1:0] part_q [3];
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  sum_q;

  always_comb begin
    logic signed [PROD_W-1:0] px_ext;
    logic signed [PROD_W-1:0] k_ext;
    for (int t = 0; t < NUM_TAPS; t++) begin
      px_ext    = PROD_W'($signed({1'b0, win_i[t]}));
      k_ext     = PROD_W'($signed(coeff_i[t*COEFF_BITS +: COEFF_BITS]));
      prod_d[t] = px_ext * k_ext;
    end
  end

  // Each row of three products is summed first, then the three rows.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      part_d[r] = PART_W'(prod_q[3*r]) + PART_W'(prod_q[3*r+1]) + PART_W'(prod_q[3*r+2]);
    end
    sum_d = SUM_W'(part_q[0]) + SUM_W'(part_q[1]) + SUM_W'(part_q[2]);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    part_q <= part_d;
    sum_q  <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ===== rtl/rgbc_round_div.sv =====
`default_nettype none
`include "assert_macros.svh"

// Pipelined restoring divider: rounds a channel sum half away from zero,
// then clamps to 0..255. One quotient bit is resolved per stage.
module rgbc_round_div import rgbc_pkg::*; #(
  parameter int unsigned COEFF_BITS = COEFF_BITS_DEF,
  localparam int unsigned SUM_W = sum_width(COEFF_BITS),
  localparam int unsigned NUM_W = ((SUM_W > DIV_W + 1) ? SUM_W : DIV_W + 1) + 1,
  localparam int unsigned REM_W = (NUM_W > DIV_W + 1 + Q_BITS) ? NUM_W : DIV_W + 1 + Q_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [SUM_W-1:0] sum_i,
  input  logic [DIV_W-1:0]        div_i,
  output logic [CH_W-1:0]         chan_o
);

  logic [REM_W-1:0]  rem_q [Q_BITS+1];
  logic [Q_BITS-1:0] quo_q [Q_BITS+1];
  logic              neg_q [Q_BITS+1];
  logic [REM_W-1:0]  num_d;
  logic [REM_W-1:0]  den;

  // Rounding is folded into the dividend: (2*sum + d) / (2*d).
  assign den   = REM_W'({div_i, 1'b0});
  assign num_d = sum_i[SUM_W-1] ? '0
               : REM_W'({sum_i[SUM_W-2:0], 1'b0}) + REM_W'(div_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q[0] <= '0;
      quo_q[0] <= '0;
      neg_q[0] <= 1'b0;
    end else begin
      rem_q[0] <= num_d;
      quo_q[0] <= '0;
      neg_q[0] <= sum_i[SUM_W-1];
    end
  end

  for (genvar s = 0; s < Q_BITS; s++) begin : g_step
    logic [REM_W-1:0] cmp;
    logic             ge;

    assign cmp = den << (Q_BITS - 1 - s);
    assign ge  = (rem_q[s] >= cmp);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_q[s+1] <= '0;
        quo_q[s+1] <= '0;
        neg_q[s+1] <= 1'b0;
      end else begin
        rem_q[s+1] <= ge ? rem_q[s] - cmp : rem_q[s];
        quo_q[s+1] <= {quo_q[s][Q_BITS-2:0], ge};
        neg_q[s+1] <= neg_q[s];
      end
    end

    `RGBC_ASSERT(a_rem_shrinks, clk_i, rst_ni, rem_q[s+1] <= $past(rem_q[s]), "remainder grew")
  end

  // The top quotient bit flags a quotient above 255.
  assign chan_o = neg_q[Q_BITS]            ? '0
                : quo_q[Q_BITS][Q_BITS-1]  ? '1
                : quo_q[Q_BITS][CH_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/rgb_3x3_convolution_unit.sv =====
// 3x3 RGB888 convolution with a signed kernel, rounding divide and clamp.
// The done_o strobe trails start by the MAC lane, divider and output register.
// Throughput: one window word per clock; busy never rises, and the result
// pipeline has no stall since the receiver takes every done_o word.
// Reset: pipeline empties, kernel becomes the identity on the middle-row
// right tap, divisor becomes 1.
`default_nettype none
`include "assert_macros.svh"

module rgb_3x3_convolution_unit import rgbc_pkg::*; #(
  parameter int unsigned COEFF_BITS = COEFF_BITS_DEF,
  localparam int unsigned KROW_W = 3 * COEFF_BITS,
  localparam int unsigned DATA_W = (KROW_W > DIV_W) ? KROW_W : DIV_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Window command.
  input  logic              start,
  output logic              busy,
  input  logic [PIX_W-1:0]  pixel_top_left_i,
  input  logic [PIX_W-1:0]  pixel_top_mid_i,
  input  logic [PIX_W-1:0]  pixel_top_right_i,
  input  logic [PIX_W-1:0]  pixel_mid_left_i,
  input  logic [PIX_W-1:0]  center_pixel_i,
  input  logic [PIX_W-1:0]  pixel_mid_right_i,
  input  logic [PIX_W-1:0]  pixel_bottom_left_i,
  input  logic [PIX_W-1:0]  pixel_bottom_mid_i,
  input  logic [PIX_W-1:0]  pixel_bottom_right_i,
  // Result word, valid for exactly the cycle in which done_o is high.
  output logic              done_o,
  output logic [PIX_W-1:0]  filtered_pixel_o,
  // Configuration write port.
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [DATA_W-1:0] cfg_wdata_i
);

  // Total depth: MAC lane, dividend stage, one stage per quotient bit, and
  // the output register that merges the three channels.
  localparam int unsigned LAT = MAC_STAGES + 1 + Q_BITS + 1;

  logic [KROW_W-1:0] ktop_q, kmid_q, kbot_q;
  logic [DIV_W-1:0]  ndiv_q;
  logic [DIV_W-1:0]  div_eff;

  logic [LAT-1:0]    vld_q;
  logic              accept;

  logic [NUM_TAPS-1:0][PIX_W-1:0] pix;
  chan_win_t                      win [NUM_CH];
  logic [NUM_TAPS*COEFF_BITS-1:0] coeff_all;
  logic [CH_W-1:0]                chan [NUM_CH];
  logic [PIX_W-1:0]               filt_d;
  logic [PIX_W-1:0]               filt_q;

  // Every cycle can take a new window, so the command side never waits.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers. Kernel rows are packed left column lowest, so
  // concatenating the rows bottom-first puts tap t at bits t*COEFF_BITS.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ktop_q <= '0;
      kmid_q <= KMID_RST[KROW_W-1:0];
      kbot_q <= '0;
      ndiv_q <= DIV_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KTOP: ktop_q <= cfg_wdata_i[KROW_W-1:0];
        REG_KMID: kmid_q <= cfg_wdata_i[KROW_W-1:0];
        REG_KBOT: kbot_q <= cfg_wdata_i[KROW_W-1:0];
        REG_NDIV: ndiv_q <= cfg_wdata_i[DIV_W-1:0];
        default:  ;
      endcase
    end
  end

  assign coeff_all = {kbot_q, kmid_q, ktop_q};

  // A divisor of zero behaves as one.
  assign div_eff = (ndiv_q == '0) ? DIV_W'(1) : ndiv_q;

  assign pix[0] = pixel_top_left_i;
  assign pix[1] = pixel_top_mid_i;
  assign pix[2] = pixel_top_right_i;
  assign pix[3] = pixel_mid_left_i;
  assign pix[4] = center_pixel_i;
  assign pix[5] = pixel_mid_right_i;
  assign pix[6] = pixel_bottom_left_i;
  assign pix[7] = pixel_bottom_mid_i;
  assign pix[8] = pixel_bottom_right_i;

  // Lane 0 is red (high byte), lane 2 is blue (low byte).
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      for (int t = 0; t < NUM_TAPS; t++) begin
        win[c][t] = pix[t][PIX_W-1-c*CH_W -: CH_W];
      end
    end
  end

  // One multiply-accumulate lane and one rounding divider per channel. The
  // configuration must only be written while the pipeline is empty (the block
  // does not enforce this), so every stage can read the registers directly.
  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    logic signed [sum_width(COEFF_BITS)-1:0] sum;

    rgbc_mac_lane #(
      .COEFF_BITS (COEFF_BITS)
    ) u_mac (
      .clk_i   (clk_i),
      .win_i   (win[c]),
      .coeff_i (coeff_all),
      .sum_o   (sum)
    );

    rgbc_round_div #(
      .COEFF_BITS (COEFF_BITS)
    ) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .sum_i  (sum),
      .div_i  (div_eff),
      .chan_o (chan[c])
    );
  end

  // Merge the three channels back into one RGB888 word.
  always_comb begin
    filt_d = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      filt_d[PIX_W-1-c*CH_W -: CH_W] = chan[c];
    end
  end

  always_ff @(posedge clk_i) begin
    filt_q <= filt_d;
  end

  // A valid bit travels alongside the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  assign done_o           = vld_q[LAT-1];
  assign filtered_pixel_o = filt_q;

  `RGBC_ASSERT(a_fixed_latency, clk_i, rst_ni, accept |-> ##LAT done_o, "result strobe missing")
  `RGBC_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy, "command side stalled")

endmodule

`default_nettype wire
